/* rtl/gncm_pkg.sv */
// Shared types, constants and the control store for the grid neighbourhood block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package gncm_pkg;

  // Port widths fixed by the interface
  localparam int ROW_W  = 6;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 7;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  // Register word index (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Control store steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] ST_N0   = 4'd1;
  localparam logic [STEP_W-1:0] ST_N1   = 4'd2;
  localparam logic [STEP_W-1:0] ST_N2   = 4'd3;
  localparam logic [STEP_W-1:0] ST_N3   = 4'd4;
  localparam logic [STEP_W-1:0] ST_N4   = 4'd5;
  localparam logic [STEP_W-1:0] ST_N5   = 4'd6;
  localparam logic [STEP_W-1:0] ST_N6   = 4'd7;
  localparam logic [STEP_W-1:0] ST_N7   = 4'd8;
  localparam logic [STEP_W-1:0] ST_N8   = 4'd9;
  localparam logic [STEP_W-1:0] ST_TAIL = 4'd10;
  localparam logic [STEP_W-1:0] ST_EMIT = 4'd11;

  typedef enum logic [1:0] {
    D_NEG,
    D_ZERO,
    D_POS
  } delta_e;

  // Sequencing: fall through, wait for a query beat, branch on bad cell, wait for output slot
  typedef enum logic [1:0] {
    C_SEQ,
    C_TAKE,
    C_BAD,
    C_EMIT
  } cond_e;

  typedef struct packed {
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              take;
    logic              clr;
    logic              chk;
    logic              rd;
    logic              acc;
    logic              emit;
    delta_e            dr;
    delta_e            dc;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } cfg_t;

  // Row/col plus offset; wrap below zero lands on 127, which is never inside the grid
  function automatic logic [CFG_W-1:0] delta_add(input logic [CFG_W-1:0] base,
                                                 input delta_e d);
    logic [CFG_W-1:0] res;
    unique case (d)
      D_NEG:   res = base - 7'd1;
      D_POS:   res = base + 7'd1;
      default: res = base;
    endcase
    return res;
  endfunction

  function automatic ctrl_t nb_word(input delta_e dr, input delta_e dc, input logic first);
    ctrl_t w;
    w = '{cond: (first ? C_BAD : C_SEQ), target: ST_EMIT, take: 1'b0, clr: first,
          chk: first, rd: 1'b1, acc: !first, emit: 1'b0, dr: dr, dc: dc};
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] s);
    ctrl_t w;
    unique case (s)
      ST_IDLE: w = '{cond: C_TAKE, target: ST_N0, take: 1'b1, clr: 1'b0, chk: 1'b0,
                     rd: 1'b0, acc: 1'b0, emit: 1'b0, dr: D_ZERO, dc: D_ZERO};
      ST_N0:   w = nb_word(D_NEG,  D_NEG,  1'b1);
      ST_N1:   w = nb_word(D_NEG,  D_ZERO, 1'b0);
      ST_N2:   w = nb_word(D_NEG,  D_POS,  1'b0);
      ST_N3:   w = nb_word(D_ZERO, D_NEG,  1'b0);
      ST_N4:   w = nb_word(D_ZERO, D_ZERO, 1'b0);
      ST_N5:   w = nb_word(D_ZERO, D_POS,  1'b0);
      ST_N6:   w = nb_word(D_POS,  D_NEG,  1'b0);
      ST_N7:   w = nb_word(D_POS,  D_ZERO, 1'b0);
      ST_N8:   w = nb_word(D_POS,  D_POS,  1'b0);
      ST_TAIL: w = '{cond: C_SEQ, target: ST_EMIT, take: 1'b0, clr: 1'b0, chk: 1'b0,
                     rd: 1'b0, acc: 1'b1, emit: 1'b0, dr: D_ZERO, dc: D_ZERO};
      ST_EMIT: w = '{cond: C_EMIT, target: ST_IDLE, take: 1'b0, clr: 1'b0, chk: 1'b0,
                     rd: 1'b0, acc: 1'b0, emit: 1'b1, dr: D_ZERO, dc: D_ZERO};
      default: w = '{cond: C_EMIT, target: ST_IDLE, take: 1'b0, clr: 1'b0, chk: 1'b0,
                     rd: 1'b0, acc: 1'b0, emit: 1'b0, dr: D_ZERO, dc: D_ZERO};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/grid_neighbourhood_count_max.sv */
// Top level: 3x3 neighborhood max and nonzero count over a stored grid.
// Depends on gncm_pkg, gncm_cfg, gncm_seq and gncm_dp.
//
// A write beat (action 0) stores one cell; nothing comes out. A query beat (action 1)
// occupies the block: the sequencer reads the nine window cells one per cycle through
// the single read port of the cell store, then a tail step folds in the last read and
// the emit step loads the result register. A query whose cell lies outside rows_in_use x
// cols_in_use returns bad_position with zeros.
// in_stall_o is low only while the sequencer waits for a beat; the result register lets
// the next beat in while an earlier result is still stalled. The cell store has no reset;
// reading a cell never written since reset returns an unspecified value.
`default_nettype none

module grid_neighbourhood_count_max
  import gncm_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [APB_AW-1:0] paddr,
  input  wire logic        [APB_DW-1:0] pwdata,
  output logic             [APB_DW-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     in_action_i,
  input  wire logic         [ROW_W-1:0] in_row_i,
  input  wire logic         [ROW_W-1:0] in_col_i,
  input  wire logic signed  [VAL_W-1:0] in_cell_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic              [CNT_W-1:0] out_nonzero_count_o,
  output logic signed       [VAL_W-1:0] out_window_max_o,
  output logic                          out_bad_position_o
);

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t sts;

  gncm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gncm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  gncm_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .cfg_i               (cfg),
    .in_valid_i          (in_valid_i),
    .in_action_i         (in_action_i),
    .in_row_i            (in_row_i),
    .in_col_i            (in_col_i),
    .in_cell_value_i     (in_cell_value_i),
    .out_stall_i         (out_stall_i),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_nonzero_count_o (out_nonzero_count_o),
    .out_window_max_o    (out_window_max_o),
    .out_bad_position_o  (out_bad_position_o)
  );

  assign in_stall_o = !ctrl.take;

endmodule

`default_nettype wire

/* rtl/gncm_cfg.sv */
// APB register file: rows_in_use and cols_in_use.
// Depends on gncm_pkg.
`default_nettype none

module gncm_cfg
  import gncm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr) begin
      unique case (paddr[2])
        REG_ROWS: rows_d = pwdata[CFG_W-1:0];
        REG_COLS: cols_d = pwdata[CFG_W-1:0];
        default:  rows_d = rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign prdata     = (paddr[2] == REG_COLS) ? APB_DW'(cols_q) : APB_DW'(rows_q);
  assign cfg_o.rows = rows_q;
  assign cfg_o.cols = cols_q;

endmodule

`default_nettype wire

/* rtl/gncm_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on gncm_pkg (ucode table, ctrl_t, stat_t).
`default_nettype none

module gncm_seq
  import gncm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_action_i,
  input  wire stat_t sts_i,
  output ctrl_t      ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             ctrl;

  assign ctrl   = ucode(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      C_SEQ:   step_d = step_q + 4'd1;
      C_TAKE:  step_d = (in_valid_i && in_action_i == ACT_QUERY) ? ctrl.target : step_q;
      C_BAD:   step_d = sts_i.bad ? ctrl.target : step_q + 4'd1;
      C_EMIT:  step_d = sts_i.out_free ? ctrl.target : step_q;
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/gncm_dp.sv */
// Datapath: cell store, neighbor address and bounds, max/count accumulator, result register.
// Depends on gncm_pkg; driven by the control word from gncm_seq.
`default_nettype none

module gncm_dp
  import gncm_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_t                   ctrl_i,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_action_i,
  input  wire logic        [ROW_W-1:0] in_row_i,
  input  wire logic        [ROW_W-1:0] in_col_i,
  input  wire logic signed [VAL_W-1:0] in_cell_value_i,
  input  wire logic                    out_stall_i,
  output stat_t                        sts_o,
  output logic                         out_valid_o,
  output logic             [CNT_W-1:0] out_nonzero_count_o,
  output logic signed      [VAL_W-1:0] out_window_max_o,
  output logic                         out_bad_position_o
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [VALUE_BITS-1:0]        mem_q [DEPTH];
  logic [CFG_W-1:0]             nrows, ncols;
  logic [ROW_W-1:0]             r0_q, c0_q;
  logic [CFG_W-1:0]             nb_row, nb_col;
  logic                         nb_ok;
  logic [ADDR_W-1:0]            rd_addr, wr_addr;
  logic                         beat, wr_en, q_en;
  logic [VALUE_BITS-1:0]        wdata;
  logic signed [VALUE_BITS-1:0] rdata_q;
  logic                         rd_ok_q;
  logic                         any_q;
  logic signed [VALUE_BITS-1:0] best_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         bad_q;
  logic                         out_free;
  logic [VAL_W-1:0]             max_ext;
  logic                         out_valid_q;
  logic [CNT_W-1:0]             out_cnt_q;
  logic [VAL_W-1:0]             out_max_q;
  logic                         out_bad_q;

  assign nrows = (32'(cfg_i.rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : cfg_i.rows;
  assign ncols = (32'(cfg_i.cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg_i.cols;

  assign beat  = ctrl_i.take & in_valid_i;
  assign q_en  = beat & (in_action_i == ACT_QUERY);
  assign wr_en = beat & (in_action_i == ACT_WRITE)
               & (32'(in_row_i) < MAX_ROWS) & (32'(in_col_i) < MAX_COLS);

  assign wr_addr = ADDR_W'(32'(in_row_i) * MAX_COLS + 32'(in_col_i));

  generate
    if (VALUE_BITS <= VAL_W) begin : g_wnarrow
      assign wdata = in_cell_value_i[VALUE_BITS-1:0];
    end else begin : g_wwide
      assign wdata = {{(VALUE_BITS-VAL_W){1'b0}}, in_cell_value_i};
    end
  endgenerate

  assign nb_row  = delta_add({1'b0, r0_q}, ctrl_i.dr);
  assign nb_col  = delta_add({1'b0, c0_q}, ctrl_i.dc);
  assign nb_ok   = (nb_row < nrows) && (nb_col < ncols);
  assign rd_addr = ADDR_W'(32'(nb_row) * MAX_COLS + 32'(nb_col));

  assign sts_o.bad      = ({1'b0, r0_q} >= nrows) || ({1'b0, c0_q} >= ncols);
  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wdata;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_en) begin
      r0_q <= in_row_i;
      c0_q <= in_col_i;
    end
    if (ctrl_i.chk) begin
      bad_q <= sts_o.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
      any_q   <= 1'b0;
      best_q  <= '0;
      cnt_q   <= '0;
    end else begin
      rd_ok_q <= ctrl_i.rd & nb_ok;
      if (ctrl_i.clr) begin
        any_q  <= 1'b0;
        best_q <= '0;
        cnt_q  <= '0;
      end else if (ctrl_i.acc && rd_ok_q) begin
        any_q <= 1'b1;
        cnt_q <= cnt_q + CNT_W'(rdata_q != '0);
        if (!any_q || rdata_q > best_q) begin
          best_q <= rdata_q;
        end
      end
    end
  end

  // Result carries the VALUE_BITS pattern zero-filled, not sign-extended
  generate
    if (VALUE_BITS >= VAL_W) begin : g_onarrow
      assign max_ext = best_q[VAL_W-1:0];
    end else begin : g_owide
      assign max_ext = {{(VAL_W-VALUE_BITS){1'b0}}, best_q};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit && out_free) begin
      out_bad_q <= bad_q;
      out_cnt_q <= bad_q ? '0 : cnt_q;
      out_max_q <= bad_q ? '0 : max_ext;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_nonzero_count_o = out_cnt_q;
  assign out_window_max_o    = out_max_q;
  assign out_bad_position_o  = out_bad_q;

endmodule

`default_nettype wire
